// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tidp_pkg.sv =====
package tidp_pkg;

    localparam int LANES     = 4;
    localparam int ACT_W     = 8;
    localparam int CODE_W    = 2;
    localparam int VLANE_W   = 3;
    localparam int PROD_W    = ACT_W + 1;
    localparam int ACC_W     = 24;
    localparam int SUM_W     = ACC_W + 2;
    localparam int SCALE_W   = 24;
    localparam int FRAC_BITS = 20;
    localparam int DOT_W     = 32;

    // first product: acc (signed) times scale (zero-extended)
    localparam int M1_W = ACC_W + SCALE_W + 1;
    localparam int P1_W = M1_W - FRAC_BITS;
    localparam int M2_W = P1_W + SCALE_W + 1;
    localparam int P2_W = M2_W - FRAC_BITS;

    localparam int CFG_IDX_W = 1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sd8388607;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -24'sd8388607;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 26'sd8388607;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -26'sd8388607;

    localparam logic signed [P2_W-1:0] DOT_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [P2_W-1:0] DOT_MIN = 34'sh3_8000_0000;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 24'h10_0000;

    localparam logic [CODE_W-1:0] CODE_NEG  = 2'b00;
    localparam logic [CODE_W-1:0] CODE_ZERO = 2'b01;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_SCALE    = 1'b1;

    typedef struct packed {
        logic accept;
        logic last;
    } acc_ctrl_t;

endpackage

// ===== rtl/tidp_lane.sv =====
module tidp_lane
    import tidp_pkg::*;
(
    input  logic [CODE_W-1:0]        code,
    input  logic signed [ACT_W-1:0]  act,
    input  logic                     en,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] act_ext;

    assign act_ext = {act[ACT_W-1], act};

    always_comb
    begin
        if (!en)
        begin
            prod = '0;
        end
        else
        begin
            unique case (code)
                CODE_NEG:  prod = -act_ext;
                CODE_ZERO: prod = '0;
                default:   prod = act_ext;
            endcase
        end
    end

endmodule

// ===== rtl/tidp_merge.sv =====
`include "assert_macros.svh"

module tidp_merge
    import tidp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  acc_ctrl_t                ctrl,
    input  logic signed [PROD_W-1:0] prod [LANES],
    output logic signed [ACC_W-1:0]  sum
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [SUM_W-1:0] sum_wide;

    always_comb
    begin
        sum_wide = {{(SUM_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
        for (int i = 0; i < LANES; i++)
        begin
            sum_wide = sum_wide + {{(SUM_W-PROD_W){prod[i][PROD_W-1]}}, prod[i]};
        end
    end

    always_comb
    begin
        priority if (sum_wide > SUM_MAX)
            sum = ACC_MAX;
        else if (sum_wide < SUM_MIN)
            sum = ACC_MIN;
        else
            sum = sum_wide[ACC_W-1:0];
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.accept)
        begin
            acc_next = ctrl.last ? '0 : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    `ASSERT_NEXT(a_acc_clear, clk, rst_n, ctrl.accept && ctrl.last, acc_reg == '0, "accumulator not cleared after last")
    `ASSERT_IMPLIES(a_acc_range, clk, rst_n, 1'b1, (acc_reg <= ACC_MAX) && (acc_reg >= ACC_MIN), "accumulator out of range")

endmodule

// ===== rtl/tidp_scale.sv =====
`include "assert_macros.svh"

module tidp_scale
    import tidp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic signed [ACC_W-1:0] load_sum,
    input  logic [SCALE_W-1:0]      weight_scale,
    input  logic [SCALE_W-1:0]      activation_scale,
    output logic                    ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [ACC_W-1:0] dot_sum,
    output logic signed [DOT_W-1:0] scaled_dot
);

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic vo_reg, vo_next;
    logic adv_o, adv2;

    logic signed [ACC_W-1:0] s1_sum_reg;
    logic signed [ACC_W-1:0] s2_sum_reg;
    logic signed [P1_W-1:0]  s2_p1_reg;
    logic signed [ACC_W-1:0] dot_sum_reg;
    logic signed [DOT_W-1:0] scaled_reg;

    logic signed [M1_W-1:0] m1;
    logic signed [M2_W-1:0] m2;
    logic signed [P2_W-1:0] p2;
    logic signed [DOT_W-1:0] p2_sat;

    assign adv_o = !vo_reg || out_ready;
    assign adv2  = !v2_reg || adv_o;
    assign ready = !v1_reg || adv2;

    assign v1_next = ready ? load : v1_reg;
    assign v2_next = adv2 ? v1_reg : v2_reg;
    assign vo_next = adv_o ? v2_reg : vo_reg;

    // the part-selects below give floor division by 2^20
    assign m1 = s1_sum_reg * $signed({1'b0, weight_scale});
    assign m2 = s2_p1_reg * $signed({1'b0, activation_scale});
    assign p2 = m2[M2_W-1:FRAC_BITS];

    always_comb
    begin
        priority if (p2 > DOT_MAX)
            p2_sat = DOT_MAX[DOT_W-1:0];
        else if (p2 < DOT_MIN)
            p2_sat = DOT_MIN[DOT_W-1:0];
        else
            p2_sat = p2[DOT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            s1_sum_reg <= load_sum;
        end
        if (adv2 && v1_reg)
        begin
            s2_sum_reg <= s1_sum_reg;
            s2_p1_reg  <= m1[M1_W-1:FRAC_BITS];
        end
        if (adv_o && v2_reg)
        begin
            dot_sum_reg <= s2_sum_reg;
            scaled_reg  <= p2_sat;
        end
    end

    assign out_valid  = vo_reg;
    assign dot_sum    = dot_sum_reg;
    assign scaled_dot = scaled_reg;

    `ASSERT_NEXT(a_s2_hold, clk, rst_n, v2_reg && !adv_o, v2_reg, "scaling stage dropped a result")
    `ASSERT_IMPLIES(a_dot_range, clk, rst_n, vo_reg, (dot_sum_reg <= ACC_MAX) && (dot_sum_reg >= ACC_MIN), "dot sum out of range")

endmodule

// ===== rtl/ternary_int8_dot_product_top.sv =====
// channel   dir  payload
// s_axis    in   tdata: weight_byte, act_lane0..3, valid_lanes; tlast: last
// m_axis    out  tdata: dot_sum, scaled_dot
// cfg       in   cfg_we / cfg_index / cfg_data (0 weight_scale, 1 activation_scale)
//
// one input item per cycle while s_tready is high; the four lanes and the accumulator add are combinational
// a result passes the sum register, product register and output register after the last
// item is taken; a new vector may start on the very next cycle
// a stalled result backs up the scaling stages and then holds off s_tready
// rst_n clears the accumulator and stage valids, scales return to 1.0
module ternary_int8_dot_product_top
    import tidp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // weight_byte[7:0], act_lane0[15:8], act_lane1[23:16], act_lane2[31:24],
    // act_lane3[39:32], valid_lanes[42:40], zero pad[47:43]
    input  logic [47:0]          s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // dot_sum[23:0], scaled_dot[55:24]
    output logic [55:0]          m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SCALE_W-1:0]   cfg_data
);

    logic [SCALE_W-1:0] weight_scale_reg;
    logic [SCALE_W-1:0] act_scale_reg;

    logic [7:0]                weight_byte;
    logic signed [ACT_W-1:0]   act [LANES];
    logic [VLANE_W-1:0]        valid_lanes;
    logic signed [PROD_W-1:0]  prod [LANES];
    logic signed [ACC_W-1:0]   sum;
    acc_ctrl_t                 ctrl;
    logic signed [ACC_W-1:0]   dot_sum;
    logic signed [DOT_W-1:0]   scaled_dot;

    assign weight_byte = s_tdata[7:0];
    assign valid_lanes = s_tdata[42:40];

    assign ctrl.accept = s_tvalid && s_tready;
    assign ctrl.last   = s_tlast;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        assign act[i] = s_tdata[8 + ACT_W*i +: ACT_W];

        tidp_lane u_lane (
            .code (weight_byte[CODE_W*i +: CODE_W]),
            .act  (act[i]),
            .en   (valid_lanes > VLANE_W'(i)),
            .prod (prod[i])
        );
    end

    tidp_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .prod  (prod),
        .sum   (sum)
    );

    tidp_scale u_scale (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (ctrl.accept && ctrl.last),
        .load_sum         (sum),
        .weight_scale     (weight_scale_reg),
        .activation_scale (act_scale_reg),
        .ready            (s_tready),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .dot_sum          (dot_sum),
        .scaled_dot       (scaled_dot)
    );

    assign m_tdata = {scaled_dot, dot_sum};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_scale_reg <= SCALE_ONE;
            act_scale_reg    <= SCALE_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WEIGHT_SCALE: weight_scale_reg <= cfg_data;
                REG_ACT_SCALE:    act_scale_reg    <= cfg_data;
            endcase
        end
    end

endmodule

// ===== test/tb_ternary_int8_dot_product_top.sv =====
`timescale 1ns / 100ps

module tb_ternary_int8_dot_product_top;
    import tidp_pkg::*;

    localparam int IDLE_PCT      = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 140;
    localparam int SAT_RUN       = 60;
    localparam logic [SCALE_W-1:0] SCALE_MAX = 24'hFF_FFFF;
    localparam longint INT32_HI = 64'sd2147483647;
    localparam longint INT32_LO = -64'sd2147483648;

    // matches the m_tdata layout: dot_sum in the low bits
    typedef struct packed {
        logic signed [DOT_W-1:0] scaled;
        logic signed [ACC_W-1:0] dot;
    } dot_result_t;

    typedef struct packed {
        logic [7:0]              wbyte;
        logic [31:0]             acts;
        logic [VLANE_W-1:0]      lanes;
        logic                    last;
        logic                    known;
        logic signed [ACC_W-1:0] dot;
        logic signed [DOT_W-1:0] scaled;
    } dir_row_t;

    localparam int DIR_COUNT = 20;
    localparam dir_row_t DIR_ROWS [0:DIR_COUNT-1] = '{
        '{8'hAA, 32'h7F7F_7F7F, 3'd4, 1'b1, 1'b1, 24'sd508, 32'sd508},
        '{8'h00, 32'h8080_8080, 3'd4, 1'b1, 1'b1, 24'sd512, 32'sd512},
        '{8'hFF, 32'h8080_8080, 3'd4, 1'b1, 1'b1, -24'sd512, -32'sd512},
        '{8'h00, 32'h7F7F_7F7F, 3'd4, 1'b1, 1'b1, -24'sd508, -32'sd508},
        '{8'h55, 32'h807F_807F, 3'd4, 1'b1, 1'b1, 24'sd0, 32'sd0},
        // no lanes count at all
        '{8'hAA, 32'h7F7F_7F7F, 3'd0, 1'b1, 1'b1, 24'sd0, 32'sd0},
        // lane counts above four behave as four; then one to three lanes
        '{8'hAA, 32'h0403_0201, 3'd5, 1'b1, 1'b1, 24'sd10, 32'sd10},
        '{8'hFF, 32'h0403_0201, 3'd6, 1'b1, 1'b1, 24'sd10, 32'sd10},
        '{8'hAA, 32'h0403_0201, 3'd7, 1'b1, 1'b1, 24'sd10, 32'sd10},
        '{8'hAA, 32'h6464_6405, 3'd1, 1'b1, 1'b1, 24'sd5, 32'sd5},
        '{8'hAA, 32'h6464_0605, 3'd2, 1'b1, 1'b1, 24'sd11, 32'sd11},
        '{8'hAA, 32'h6407_0605, 3'd3, 1'b1, 1'b1, 24'sd18, 32'sd18},
        // multi-item vectors, mixed codes
        '{8'hE4, 32'h8080_7F80, 3'd4, 1'b0, 1'b0, 24'sd0, 32'sd0},
        '{8'h1B, 32'h7F80_017F, 3'd4, 1'b0, 1'b0, 24'sd0, 32'sd0},
        '{8'h39, 32'hC0DE_1234, 3'd0, 1'b0, 1'b0, 24'sd0, 32'sd0},
        '{8'h4E, 32'h1234_5678, 3'd2, 1'b1, 1'b0, 24'sd0, 32'sd0},
        '{8'hAA, 32'h7F7F_7F7F, 3'd4, 1'b0, 1'b0, 24'sd0, 32'sd0},
        '{8'hC6, 32'h80FF_0180, 3'd7, 1'b0, 1'b0, 24'sd0, 32'sd0},
        '{8'h00, 32'h7F7F_7F7F, 3'd0, 1'b1, 1'b0, 24'sd0, 32'sd0},
        '{8'h9C, 32'h01FF_7F80, 3'd3, 1'b1, 1'b0, 24'sd0, 32'sd0}
    };

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [55:0]          m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_WEIGHT_SCALE;
    logic [SCALE_W-1:0]   cfg_data  = '0;

    // predictor state
    logic [SCALE_W-1:0] w_scale = SCALE_ONE;
    logic [SCALE_W-1:0] a_scale = SCALE_ONE;
    int                 run_sum = 0;

    dot_result_t pending_dots [$];
    int          errors     = 0;
    int          items_sent = 0;
    bit          quiet      = 1'b0;
    int          stall_cycles;

    ternary_int8_dot_product_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void accumulate_item(
        input  logic [7:0]         wb,
        input  logic [31:0]        acts,
        input  logic [VLANE_W-1:0] lanes,
        input  logic               last,
        output bit                 produces,
        output dot_result_t        res
    );
        int          total;
        int          n;
        int          act;
        logic [1:0]  code;
        longint      step1;
        longint      step2;
        total = run_sum;
        n = (lanes > LANES) ? LANES : int'(lanes);
        for (int i = 0; i < n; i++)
        begin
            code = wb[2*i +: 2];
            act  = int'(signed'(acts[8*i +: 8]));
            if (code == CODE_NEG)
                total -= act;
            else if (code != CODE_ZERO)
                total += act;
        end
        if (total > int'(ACC_MAX))
            total = int'(ACC_MAX);
        if (total < int'(ACC_MIN))
            total = int'(ACC_MIN);
        run_sum  = total;
        produces = last;
        res      = '0;
        if (last)
        begin
            // arithmetic shifts floor toward minus infinity
            step1 = (longint'(total) * longint'(w_scale)) >>> FRAC_BITS;
            step2 = (step1 * longint'(a_scale)) >>> FRAC_BITS;
            if (step2 > INT32_HI)
                step2 = INT32_HI;
            if (step2 < INT32_LO)
                step2 = INT32_LO;
            res.dot    = total[ACC_W-1:0];
            res.scaled = step2[DOT_W-1:0];
            run_sum    = 0;
        end
    endfunction

    function automatic logic [7:0] rand_act();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 8'h80;
        else if (pick == 1)
            return 8'h7F;
        return 8'($urandom);
    endfunction

    task automatic send_item(
        input logic [7:0]         wb,
        input logic [31:0]        acts,
        input logic [VLANE_W-1:0] lanes,
        input logic               last,
        input logic               known,
        input dot_result_t        typed_res
    );
        dot_result_t predicted;
        bit          produces;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, lanes, acts, wb};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        accumulate_item(wb, acts, lanes, last, produces, predicted);
        if (produces)
            pending_dots.push_back(known ? typed_res : predicted);
    endtask

    task automatic send_random_vector();
        int                 len;
        logic [VLANE_W-1:0] lanes;
        logic [31:0]        acts;
        len = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
        for (int k = 0; k < len; k++)
        begin
            acts = {rand_act(), rand_act(), rand_act(), rand_act()};
            // mostly full lanes with a short tail, now and then an odd lane count
            if ($urandom_range(11) == 0)
                lanes = VLANE_W'($urandom_range(7));
            else if (k == len - 1)
                lanes = VLANE_W'($urandom_range(4, 1));
            else
                lanes = VLANE_W'(LANES);
            send_item(8'($urandom), acts, lanes, k == len - 1, 1'b0, '0);
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_dots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_scales(input logic [SCALE_W-1:0] ws, input logic [SCALE_W-1:0] as);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WEIGHT_SCALE;
        cfg_data  <= ws;
        @(posedge clk);
        cfg_index <= REG_ACT_SCALE;
        cfg_data  <= as;
        @(posedge clk);
        cfg_we    <= 1'b0;
        w_scale = ws;
        a_scale = as;
    endtask

    task automatic send_saturating_vector(input logic [7:0] wb);
        repeat (SAT_RUN)
            send_item(wb, 32'h7F7F_7F7F, VLANE_W'(LANES), 1'b0, 1'b0, '0);
        // a few random items before the closing one
        repeat (4)
            send_item(8'($urandom), {rand_act(), rand_act(), rand_act(), rand_act()},
                      VLANE_W'(LANES), 1'b0, 1'b0, '0);
        send_item(wb, 32'h7F7F_7F7F, VLANE_W'(LANES), 1'b1, 1'b0, '0);
    endtask

    // result checker and receiver backpressure
    always @(posedge clk)
    begin : rx
        dot_result_t got;
        dot_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_dots.size() == 0)
            begin
                $error("unexpected result transaction: dot_sum %0d scaled_dot %0d",
                       got.dot, got.scaled);
                errors++;
            end
            else
            begin
                want = pending_dots.pop_front();
                if (got.dot !== want.dot)
                begin
                    $error("dot_sum mismatch: expected %0d, actual %0d", want.dot, got.dot);
                    errors++;
                end
                if (got.scaled !== want.scaled)
                begin
                    $error("scaled_dot mismatch: expected %0d, actual %0d",
                           want.scaled, got.scaled);
                    errors++;
                end
            end
        end
        m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog on cycles without any transaction
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : main
        logic [SCALE_W-1:0] ws;
        logic [SCALE_W-1:0] as;
        int                 phase_end;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs at the reset scales of 1.0
        for (int r = 0; r < DIR_COUNT; r++)
            send_item(DIR_ROWS[r].wbyte, DIR_ROWS[r].acts, DIR_ROWS[r].lanes,
                      DIR_ROWS[r].last, DIR_ROWS[r].known,
                      {DIR_ROWS[r].scaled, DIR_ROWS[r].dot});
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin ws = SCALE_ONE; as = SCALE_ONE; end
                1: begin ws = '0;        as = SCALE_ONE; end
                2: begin ws = SCALE_MAX; as = SCALE_MAX; end
                3: begin ws = SCALE_ONE; as = '0;        end
                4: begin ws = 24'd1;     as = SCALE_MAX; end
                5: begin ws = SCALE_MAX; as = 24'd1;     end
                default: begin ws = SCALE_W'($urandom); as = SCALE_W'($urandom); end
            endcase
            set_scales(ws, as);
            quiet = (p == 2);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                send_random_vector();
            wait_drained();
        end
        quiet = 1'b0;

        // longer vectors at full scale with lane products of +127 and -127
        set_scales(SCALE_MAX, SCALE_MAX);
        send_saturating_vector(8'hAA);
        send_saturating_vector(8'h00);

        wait_drained();
        if (pending_dots.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_dots.size());
            errors++;
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
